/* src/ihc_pkg.sv */
package ihc_pkg;

    // Byte offsets of the captured IPv4 header fields.
    localparam logic [15:0] POS_VERSION_IHL = 16'd0;
    localparam logic [15:0] POS_LENGTH_HI   = 16'd2;
    localparam logic [15:0] POS_LENGTH_LO   = 16'd3;
    localparam logic [15:0] POS_PROTOCOL    = 16'd9;
    localparam logic [15:0] POS_CSUM_HI     = 16'd10;
    localparam logic [15:0] POS_CSUM_LO     = 16'd11;
    localparam logic [15:0] POS_SRC_FIRST   = 16'd12;
    localparam logic [15:0] POS_SRC_LAST    = 16'd15;
    localparam logic [15:0] POS_DST_FIRST   = 16'd16;
    localparam logic [15:0] POS_DST_LAST    = 16'd19;

    localparam logic [15:0] COUNT_MAX         = 16'hFFFF;
    localparam logic [5:0]  MIN_HEADER_BYTES  = 6'd20;
    localparam logic [3:0]  IP_VERSION_4      = 4'd4;
    localparam logic [31:0] LOCAL_ADDR_RESET  = 32'hC0A8_0A01;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_TCP  = 8'd6;

    // Depth of the queue between the byte parser and the verdict stage.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        VERDICT_OK           = 3'd0,
        VERDICT_SHORT        = 3'd1,
        VERDICT_NOT_V4       = 3'd2,
        VERDICT_BAD_IHL      = 3'd3,
        VERDICT_BAD_LENGTH   = 3'd4,
        VERDICT_BAD_CHECKSUM = 3'd5,
        VERDICT_NOT_OURS     = 3'd6
    } verdict_t;

    typedef enum logic [1:0] {
        ROUTE_ICMP    = 2'd0,
        ROUTE_UDP     = 2'd1,
        ROUTE_TCP     = 2'd2,
        ROUTE_UNKNOWN = 2'd3
    } route_t;

    // Everything the verdict stage needs about one finished packet.
    typedef struct packed {
        logic [15:0] byte_count;
        logic [7:0]  version_ihl;
        logic [15:0] total_length;
        logic [7:0]  protocol_field;
        logic [15:0] sum_accumulator;
        logic [15:0] received_checksum;
        logic [31:0] source_field;
        logic [31:0] dest_field;
    } packet_summary_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Ones' complement addition with end-around carry.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

/* src/ihc_channels.sv */
// Byte request channel into the block.
interface ihc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result request channel out of the block.
interface ihc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [1:0]  route;
    logic [7:0]  protocol_number;
    logic [5:0]  header_bytes;
    logic [15:0] payload_bytes;
    logic [31:0] source_address;
    logic [31:0] dest_address;

    modport source (output valid, output verdict, output route, output protocol_number,
                    output header_bytes, output payload_bytes, output source_address,
                    output dest_address, input ready);
    modport sink (input valid, input verdict, input route, input protocol_number,
                  input header_bytes, input payload_bytes, input source_address,
                  input dest_address, output ready);
endinterface

/* src/ihc_front.sv */
module ihc_front #(
    parameter int MAX_HEADER_BYTES = 60
) (
    input  logic                     clk,
    input  logic                     rst_n,
    ihc_byte_if.sink                 byte_in,
    input  ihc_pkg::queue_status_t   q_status,
    output logic                     push,
    output ihc_pkg::packet_summary_t push_data
);

    localparam logic [15:0] MaxHeader = 16'(MAX_HEADER_BYTES);

    logic [15:0] byte_count_reg, byte_count_next;
    logic [7:0]  version_ihl_reg, version_ihl_next;
    logic [15:0] total_length_reg, total_length_next;
    logic [7:0]  protocol_reg, protocol_next;
    logic [31:0] source_reg, source_next;
    logic [31:0] dest_reg, dest_next;
    logic [15:0] sum_reg, sum_next;
    logic [15:0] csum_reg, csum_next;
    logic [7:0]  held_reg, held_next;

    logic [15:0] pos;
    logic [5:0]  hdr_len;
    logic [7:0]  sum_byte;
    logic        accept;

    assign byte_in.ready = !q_status.full;
    assign accept        = byte_in.valid && byte_in.ready;
    assign pos           = byte_count_reg;

    // Field capture, checksum accumulation and byte counting for one byte.
    always_comb
    begin
        version_ihl_next  = version_ihl_reg;
        total_length_next = total_length_reg;
        protocol_next     = protocol_reg;
        source_next       = source_reg;
        dest_next         = dest_reg;
        sum_next          = sum_reg;
        csum_next         = csum_reg;
        held_next         = held_reg;

        case (pos) inside
            ihc_pkg::POS_VERSION_IHL: version_ihl_next = byte_in.data_byte;
            ihc_pkg::POS_LENGTH_HI:   total_length_next[15:8] = byte_in.data_byte;
            ihc_pkg::POS_LENGTH_LO:   total_length_next[7:0] = byte_in.data_byte;
            ihc_pkg::POS_PROTOCOL:    protocol_next = byte_in.data_byte;
            ihc_pkg::POS_CSUM_HI:     csum_next[15:8] = byte_in.data_byte;
            ihc_pkg::POS_CSUM_LO:     csum_next[7:0] = byte_in.data_byte;
            [ihc_pkg::POS_SRC_FIRST:ihc_pkg::POS_SRC_LAST]:
                source_next = {source_reg[23:0], byte_in.data_byte};
            [ihc_pkg::POS_DST_FIRST:ihc_pkg::POS_DST_LAST]:
                dest_next = {dest_reg[23:0], byte_in.data_byte};
            default: ;
        endcase

        // The checksum field itself counts as zero in the sum.
        hdr_len  = {version_ihl_next[3:0], 2'b00};
        sum_byte = (pos == ihc_pkg::POS_CSUM_HI || pos == ihc_pkg::POS_CSUM_LO)
                   ? 8'd0 : byte_in.data_byte;
        if (pos < {10'd0, hdr_len} && pos < MaxHeader)
        begin
            if (!pos[0])
            begin
                held_next = sum_byte;
            end
            else
            begin
                sum_next = ihc_pkg::ones_add(sum_reg, {held_reg, sum_byte});
            end
        end

        byte_count_next = (byte_count_reg == ihc_pkg::COUNT_MAX)
                          ? byte_count_reg : byte_count_reg + 16'd1;
    end

    // A finished packet goes to the queue with its final field values.
    assign push = accept && byte_in.last_byte;
    always_comb
    begin
        push_data.byte_count        = byte_count_next;
        push_data.version_ihl       = version_ihl_next;
        push_data.total_length      = total_length_next;
        push_data.protocol_field    = protocol_next;
        push_data.sum_accumulator   = sum_next;
        push_data.received_checksum = csum_next;
        push_data.source_field      = source_next;
        push_data.dest_field        = dest_next;
    end

    // Per-packet state; cleared after the last byte of each packet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            version_ihl_reg  <= '0;
            total_length_reg <= '0;
            protocol_reg     <= '0;
            source_reg       <= '0;
            dest_reg         <= '0;
            sum_reg          <= '0;
            csum_reg         <= '0;
            held_reg         <= '0;
        end
        else if (accept)
        begin
            if (byte_in.last_byte)
            begin
                byte_count_reg   <= '0;
                version_ihl_reg  <= '0;
                total_length_reg <= '0;
                protocol_reg     <= '0;
                source_reg       <= '0;
                dest_reg         <= '0;
                sum_reg          <= '0;
                csum_reg         <= '0;
                held_reg         <= '0;
            end
            else
            begin
                byte_count_reg   <= byte_count_next;
                version_ihl_reg  <= version_ihl_next;
                total_length_reg <= total_length_next;
                protocol_reg     <= protocol_next;
                source_reg       <= source_next;
                dest_reg         <= dest_next;
                sum_reg          <= sum_next;
                csum_reg         <= csum_next;
                held_reg         <= held_next;
            end
        end
    end

endmodule

/* src/ihc_queue.sv */
module ihc_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  ihc_pkg::packet_summary_t push_data,
    input  logic                     pop,
    output ihc_pkg::packet_summary_t pop_data,
    output ihc_pkg::queue_status_t   status
);

    localparam int Depth  = ihc_pkg::QUEUE_DEPTH;
    localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CountW = $clog2(Depth + 1);

    ihc_pkg::packet_summary_t entry_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CountW-1:0] count_reg;

    assign status.full  = (count_reg == CountW'(Depth));
    assign status.empty = (count_reg == '0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    // Entry storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* src/ihc_back.sv */
module ihc_back #(
    parameter int MAX_HEADER_BYTES = 60
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [31:0]              cfg_wdata,
    input  ihc_pkg::queue_status_t   q_status,
    input  ihc_pkg::packet_summary_t pop_data,
    output logic                     pop,
    ihc_result_if.source             result_out
);

    localparam logic [5:0] MaxHeader = 6'(MAX_HEADER_BYTES);

    logic [31:0]       local_addr_reg;
    logic              valid_reg;
    ihc_pkg::verdict_t verdict_reg, verdict_next;
    ihc_pkg::route_t   route_reg, route_next;
    logic [7:0]        protocol_reg;
    logic [5:0]        hdr_reg, hdr_next;
    logic [15:0]       payload_reg, payload_next;
    logic [31:0]       source_reg;
    logic [31:0]       dest_reg;

    assign pop = !q_status.empty && (!valid_reg || result_out.ready);

    // Checks in priority order; the first one that fails sets the verdict.
    always_comb
    begin
        hdr_next     = {pop_data.version_ihl[3:0], 2'b00};
        payload_next = '0;
        if (pop_data.byte_count < {10'd0, ihc_pkg::MIN_HEADER_BYTES})
        begin
            verdict_next = ihc_pkg::VERDICT_SHORT;
        end
        else if (pop_data.version_ihl[7:4] != ihc_pkg::IP_VERSION_4)
        begin
            verdict_next = ihc_pkg::VERDICT_NOT_V4;
        end
        else if (hdr_next < ihc_pkg::MIN_HEADER_BYTES || hdr_next > MaxHeader)
        begin
            verdict_next = ihc_pkg::VERDICT_BAD_IHL;
        end
        else if (pop_data.total_length < {10'd0, hdr_next}
                 || pop_data.total_length > pop_data.byte_count)
        begin
            verdict_next = ihc_pkg::VERDICT_BAD_LENGTH;
        end
        else if (~pop_data.sum_accumulator != pop_data.received_checksum)
        begin
            verdict_next = ihc_pkg::VERDICT_BAD_CHECKSUM;
        end
        else if (pop_data.dest_field != local_addr_reg)
        begin
            verdict_next = ihc_pkg::VERDICT_NOT_OURS;
        end
        else
        begin
            verdict_next = ihc_pkg::VERDICT_OK;
            payload_next = pop_data.total_length - {10'd0, hdr_next};
        end

        case (pop_data.protocol_field)
            ihc_pkg::PROTO_ICMP: route_next = ihc_pkg::ROUTE_ICMP;
            ihc_pkg::PROTO_UDP:  route_next = ihc_pkg::ROUTE_UDP;
            ihc_pkg::PROTO_TCP:  route_next = ihc_pkg::ROUTE_TCP;
            default:             route_next = ihc_pkg::ROUTE_UNKNOWN;
        endcase
    end

    // Control state: local address register and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_addr_reg <= ihc_pkg::LOCAL_ADDR_RESET;
            valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                local_addr_reg <= cfg_wdata;
            end
            if (pop)
            begin
                valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register, loaded whenever an entry leaves the queue.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            verdict_reg  <= verdict_next;
            route_reg    <= route_next;
            protocol_reg <= pop_data.protocol_field;
            hdr_reg      <= hdr_next;
            payload_reg  <= payload_next;
            source_reg   <= pop_data.source_field;
            dest_reg     <= pop_data.dest_field;
        end
    end

    assign result_out.valid           = valid_reg;
    assign result_out.verdict         = verdict_reg;
    assign result_out.route           = route_reg;
    assign result_out.protocol_number = protocol_reg;
    assign result_out.header_bytes    = hdr_reg;
    assign result_out.payload_bytes   = payload_reg;
    assign result_out.source_address  = source_reg;
    assign result_out.dest_address    = dest_reg;

endmodule

/* src/ipv4_header_check_classify_core.sv */
// IPv4 receive header check and protocol classifier.
// byte_in carries one packet byte per request in wire order, with last_byte
// set on the final byte. result_out carries one request per packet: the
// verdict, protocol route, header and payload lengths and both addresses.
// The local address is written through cfg_we/cfg_wdata; the user must do
// so only while the block is idle, as the block does not enforce it. Reset
// loads the default address. A byte is taken in every cycle while the queue
// is not full. The parser updates its captured fields and the 16-bit ones'
// complement sum for each byte, and on the last byte hands a packet summary
// to a two-entry queue. The verdict stage pops one summary per cycle into
// the output register while it is empty or its result is being taken, and
// the register then shows the summary's result as valid. When the receiver
// stalls, the output register holds its result, the queue fills, and
// byte_in.ready falls only once the queue is full. Reset clears the packet
// state, empties the queue and drops any pending result.
module ipv4_header_check_classify_core #(
    parameter int MAX_HEADER_BYTES = 60
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [31:0]   cfg_wdata,
    ihc_byte_if.sink      byte_in,
    ihc_result_if.source  result_out
);

    ihc_pkg::queue_status_t   q_status;
    ihc_pkg::packet_summary_t push_data;
    ihc_pkg::packet_summary_t pop_data;
    logic                     push;
    logic                     pop;

    ihc_front #(
        .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    ihc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    ihc_back #(
        .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .q_status   (q_status),
        .pop_data   (pop_data),
        .pop        (pop),
        .result_out (result_out)
    );

    // The queue never takes a summary while full.
    assert property (@(posedge clk) disable iff (!rst_n) q_status.full |-> !push)
        else $error("packet summary pushed into a full queue");

    // A summary popped from the queue shows up as a valid result next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) pop |=> result_out.valid)
        else $error("popped summary did not reach the output");

    // Payload length is reported only for accepted packets.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.verdict != ihc_pkg::VERDICT_OK)
            |-> (result_out.payload_bytes == 16'd0))
        else $error("payload length reported for a rejected packet");

    // An accepted packet has a header length within the legal range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.verdict == ihc_pkg::VERDICT_OK)
            |-> (result_out.header_bytes >= ihc_pkg::MIN_HEADER_BYTES
                 && result_out.header_bytes <= 6'(MAX_HEADER_BYTES)))
        else $error("accepted packet with illegal header length");

    // A TCP route agrees with the reported protocol number.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.route == ihc_pkg::ROUTE_TCP)
            |-> (result_out.protocol_number == ihc_pkg::PROTO_TCP))
        else $error("TCP route with a different protocol number");

endmodule
